// File: rtl/mbs_pkg.sv
// Package for the mesh bounding sphere block: payload types and sizing constants.
// Used by the channel interfaces, the square root unit and the top level.
package mbs_pkg;

  localparam int CoordW  = 32;
  localparam int DiagW   = 33;
  localparam int RadW    = 2 * DiagW;
  localparam int RemW    = DiagW + 4;
  localparam int SqStepW = 3;
  localparam int SqSteps = 5;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic                     last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic        [DiagW-1:0]  diagonal;
  } result_t;

endpackage

// File: rtl/mbs_vtx_if.sv
// Vertex channel: valid/ready handshake carrying one vertex per transfer.
// Depends on mbs_pkg for the payload type.
interface mbs_vtx_if;
  logic             valid;
  logic             ready;
  mbs_pkg::vertex_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mbs_res_if.sv
// Result channel: valid/ready handshake carrying one bounding sphere per transfer.
// Depends on mbs_pkg for the payload type.
interface mbs_res_if;
  logic             valid;
  logic             ready;
  mbs_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mbs_sqrt.sv
// Iterative floor square root, one result bit per cycle, restoring method.
// Depends on mbs_pkg for the operand widths.
module mbs_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mbs_pkg::RadW-1:0]  radicand,
  output logic                      done,
  output logic [mbs_pkg::DiagW-1:0] root
);
  import mbs_pkg::*;

  localparam int CntW = $clog2(DiagW);

  logic            run_r,  run_nxt;
  logic [CntW-1:0] cnt_r,  cnt_nxt;
  logic [RadW-1:0] rad_r,  rad_nxt;
  logic [RemW-1:0] rem_r,  rem_nxt;
  logic [DiagW-1:0] root_r, root_nxt;
  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;

  assign rem_sh = {rem_r[RemW-3:0], rad_r[RadW-1 -: 2]};
  assign trial  = {{(RemW-DiagW-2){1'b0}}, root_r, 2'b01};

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = CntW'(DiagW - 1);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (run_r) begin
      rad_nxt = {rad_r[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[DiagW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[DiagW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = run_r && (cnt_r == '0);
  assign root = root_nxt;

endmodule

// File: rtl/mesh_bounding_sphere.sv
// Mesh bounding sphere: running per-axis box, center and floored diagonal.
// Vertices without the last mark are taken one per cycle while the block is idle. A last
// vertex goes through the squaring multiplier and accumulator shared by the three axes,
// then the one-bit-per-cycle square root, and then into the output register once any
// earlier result has been taken. Input is held off for that time. Reset clears the sequencer
// and output valid and arms the next vertex to seed the box.
module mesh_bounding_sphere (
  input  logic clk,
  input  logic rst_n,
  mbs_vtx_if.sink   in_vtx,
  mbs_res_if.source out_res
);
  import mbs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQR  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [SqStepW-1:0] cnt_r,   cnt_nxt;
  logic               first_r, first_nxt;
  logic               oval_r,  oval_nxt;
  result_t            res_r,   res_nxt;

  logic signed [CoordW-1:0] low_r  [0:2];
  logic signed [CoordW-1:0] high_r [0:2];
  logic signed [CoordW-1:0] low_nxt  [0:2];
  logic signed [CoordW-1:0] high_nxt [0:2];
  logic signed [CoordW-1:0] vin [0:2];

  logic [CoordW-1:0]   diff_r, diff_nxt;
  logic [2*CoordW-1:0] prod_r;
  logic [RadW-1:0]     acc_r,  acc_nxt;
  logic [CoordW:0]     ext_sel;
  logic [CoordW:0]     csum [0:2];

  logic             accept;
  logic             sq_start;
  logic             sq_done;
  logic [DiagW-1:0] sq_root;

  assign vin[0] = in_vtx.data.pos_x;
  assign vin[1] = in_vtx.data.pos_y;
  assign vin[2] = in_vtx.data.pos_z;

  assign in_vtx.ready = (state_r == ST_IDLE);
  assign accept       = in_vtx.valid && in_vtx.ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      low_nxt[i]  = low_r[i];
      high_nxt[i] = high_r[i];
      if (accept) begin
        if (first_r || (vin[i] < low_r[i])) begin
          low_nxt[i] = vin[i];
        end
        if (first_r || (vin[i] > high_r[i])) begin
          high_nxt[i] = vin[i];
        end
      end
    end
  end

  always_comb begin
    unique case (cnt_r)
      3'd0:    ext_sel = {high_r[0][CoordW-1], high_r[0]} - {low_r[0][CoordW-1], low_r[0]};
      3'd1:    ext_sel = {high_r[1][CoordW-1], high_r[1]} - {low_r[1][CoordW-1], low_r[1]};
      3'd2:    ext_sel = {high_r[2][CoordW-1], high_r[2]} - {low_r[2][CoordW-1], low_r[2]};
      default: ext_sel = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = {high_r[i][CoordW-1], high_r[i]} + {low_r[i][CoordW-1], low_r[i]};
    end
  end

  assign sq_start = (state_r == ST_SQR) && (cnt_r == SqStepW'(SqSteps - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    oval_nxt  = oval_r;
    res_nxt   = res_r;
    diff_nxt  = diff_r;
    acc_nxt   = acc_r;

    if (out_res.valid && out_res.ready) begin
      oval_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          first_nxt = in_vtx.data.last_vertex;
          if (in_vtx.data.last_vertex) begin
            state_nxt = ST_SQR;
            cnt_nxt   = '0;
            acc_nxt   = '0;
          end
        end
      end
      ST_SQR: begin
        diff_nxt = ext_sel[CoordW-1:0];
        if (cnt_r >= SqStepW'(2)) begin
          acc_nxt = acc_r + {{(RadW-2*CoordW){1'b0}}, prod_r};
        end
        if (sq_start) begin
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!oval_r || out_res.ready) begin
          state_nxt        = ST_IDLE;
          oval_nxt         = 1'b1;
          res_nxt.min_x    = low_r[0];
          res_nxt.min_y    = low_r[1];
          res_nxt.min_z    = low_r[2];
          res_nxt.max_x    = high_r[0];
          res_nxt.max_y    = high_r[1];
          res_nxt.max_z    = high_r[2];
          res_nxt.center_x = csum[0][CoordW:1];
          res_nxt.center_y = csum[1][CoordW:1];
          res_nxt.center_z = csum[2][CoordW:1];
          res_nxt.diagonal = sq_root;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      first_r <= 1'b1;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      oval_r  <= oval_nxt;
    end
    res_r  <= res_nxt;
    diff_r <= diff_nxt;
    prod_r <= diff_r * diff_r;
    acc_r  <= acc_nxt;
    for (int i = 0; i < 3; i++) begin
      low_r[i]  <= low_nxt[i];
      high_r[i] <= high_nxt[i];
    end
  end

  // The final accumulate is folded into the radicand the root unit captures.
  mbs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_nxt),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign out_res.valid = oval_r;
  assign out_res.data  = res_r;

endmodule

// File: tb/mesh_bounding_sphere_tb.sv
// Testbench for mesh_bounding_sphere: directed and random meshes through the vertex channel,
// each bounding sphere checked field by field against a local model of the box, center and diagonal.
// Depends on mbs_pkg and the mbs_vtx_if and mbs_res_if channel interfaces.
module mesh_bounding_sphere_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbs_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 400;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mbs_vtx_if vtx_if ();
  mbs_res_if res_if ();

  mesh_bounding_sphere u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vtx  (vtx_if.sink),
    .out_res (res_if.source)
  );

  always #4 clk = ~clk;

  logic signed [CoordW-1:0] box_lo [3];
  logic signed [CoordW-1:0] box_hi [3];
  bit                       seed_next = 1'b1;
  result_t                  pending_spheres [$];

  int gap_max   = 0;
  int burst_max = 1;
  int burst_left = 0;
  int stall_pct = 0;
  int stall_len_max = 1;
  int hold_seq = 0;

  int vertices_sent = 0;
  int meshes_sent = 0;
  int spheres_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic logic [DiagW-1:0] floor_sqrt(logic [67:0] s);
    logic [33:0] r;
    logic [33:0] c;
    logic [67:0] sq;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      sq = {34'd0, c} * {34'd0, c};
      if (sq <= s) r = c;
    end
    return r[DiagW-1:0];
  endfunction

  task automatic fold_vertex(vertex_t v);
    logic signed [CoordW-1:0] p [3];
    logic signed [CoordW:0]   wide;
    logic [67:0]              sum_sq;
    logic [CoordW:0]          ext;
    result_t                  r;
    p[0] = v.pos_x;
    p[1] = v.pos_y;
    p[2] = v.pos_z;
    for (int i = 0; i < 3; i++) begin
      if (seed_next) begin
        box_lo[i] = p[i];
        box_hi[i] = p[i];
      end else begin
        if (p[i] < box_lo[i]) box_lo[i] = p[i];
        if (p[i] > box_hi[i]) box_hi[i] = p[i];
      end
    end
    seed_next = 1'b0;
    if (v.last_vertex) begin
      sum_sq = '0;
      for (int i = 0; i < 3; i++) begin
        ext = {box_hi[i][CoordW-1], box_hi[i]} - {box_lo[i][CoordW-1], box_lo[i]};
        sum_sq += {35'd0, ext} * {35'd0, ext};
      end
      r.min_x = box_lo[0];
      r.min_y = box_lo[1];
      r.min_z = box_lo[2];
      r.max_x = box_hi[0];
      r.max_y = box_hi[1];
      r.max_z = box_hi[2];
      wide = {box_hi[0][CoordW-1], box_hi[0]} + {box_lo[0][CoordW-1], box_lo[0]};
      r.center_x = wide[CoordW:1];
      wide = {box_hi[1][CoordW-1], box_hi[1]} + {box_lo[1][CoordW-1], box_lo[1]};
      r.center_y = wide[CoordW:1];
      wide = {box_hi[2][CoordW-1], box_hi[2]} + {box_lo[2][CoordW-1], box_lo[2]};
      r.center_z = wide[CoordW:1];
      r.diagonal = floor_sqrt(sum_sq);
      pending_spheres.push_back(r);
      seed_next = 1'b1;
      meshes_sent++;
    end
  endtask

  // Called right after a rising edge; returns after the transfer edge and any idle gap after it.
  task automatic send_vertex(vertex_t v);
    int gap;
    vtx_if.valid <= 1'b1;
    vtx_if.data  <= v;
    do @(posedge clk); while (!vtx_if.ready);
    fold_vertex(v);
    vertices_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        vtx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_xyz(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                          logic signed [CoordW-1:0] z, bit last);
    vertex_t v;
    v.pos_x = x;
    v.pos_y = y;
    v.pos_z = z;
    v.last_vertex = last;
    send_vertex(v);
  endtask

  task automatic wait_for_spheres();
    vtx_if.valid <= 1'b0;
    do @(posedge clk); while (pending_spheres.size() != 0);
  endtask

  task automatic set_idling(int gmax, int bmax, int spct, int slen);
    gap_max = gmax;
    burst_max = bmax;
    stall_pct = spct;
    stall_len_max = slen;
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 8) return $signed($urandom_range(0, 131071)) - 65536;
    if (pick == 8) begin
      case ($urandom_range(0, 4))
        0: return CoordMin;
        1: return CoordMax;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    return $urandom_range(0, 1) ? CoordMax - $urandom_range(0, 255)
                                : CoordMin + $urandom_range(0, 255);
  endfunction

  task automatic test_single_vertex();
    send_xyz(0, 0, 0, 1'b1);
    send_xyz(CoordMax, CoordMin, -1, 1'b1);
    send_xyz(1, -1, CoordMin, 1'b1);
  endtask

  task automatic test_extreme_box();
    send_xyz(CoordMin, CoordMin, CoordMin, 1'b0);
    send_xyz(CoordMax, CoordMax, CoordMax, 1'b1);
    send_xyz(CoordMax, CoordMax, CoordMax, 1'b0);
    send_xyz(CoordMin, CoordMin, CoordMin, 1'b1);
    send_xyz(CoordMax, CoordMin, CoordMax, 1'b0);
    send_xyz(CoordMin, CoordMax, CoordMin, 1'b0);
    send_xyz(0, 0, 0, 1'b1);
  endtask

  task automatic test_center_rounding();
    send_xyz(-3, -1, 1, 1'b0);
    send_xyz(0, 0, 2, 1'b1);
    send_xyz(CoordMax, CoordMin, 7, 1'b0);
    send_xyz(CoordMax - 1, CoordMin + 1, -8, 1'b1);
  endtask

  task automatic test_reseed();
    send_xyz(100, 200, 300, 1'b1);
    send_xyz(5, 5, 5, 1'b0);
    send_xyz(6, 4, 5, 1'b0);
    send_xyz(5, 6, 4, 1'b1);
  endtask

  task automatic test_random_meshes(int n_items, int max_len, bit drain_midway);
    int items_left;
    int len;
    vertex_t v;
    items_left = n_items;
    while (items_left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 12);
      if (len > items_left) len = items_left;
      for (int i = 0; i < len; i++) begin
        v.pos_x = rand_coord();
        v.pos_y = rand_coord();
        v.pos_z = rand_coord();
        v.last_vertex = (i == len - 1);
        send_vertex(v);
      end
      items_left -= len;
      if (drain_midway && items_left <= n_items / 2 && items_left + len > n_items / 2)
        wait_for_spheres();
    end
  endtask

  task automatic test_backpressure();
    set_idling(0, 1, 0, 1);
    hold_seq++;
    for (int i = 0; i < 12; i++) send_xyz(rand_coord(), rand_coord(), rand_coord(), i % 3 == 2);
    for (int i = 0; i < 6; i++) send_xyz(rand_coord(), rand_coord(), rand_coord(), 1'b1);
    wait_for_spheres();
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random runs of ready and stall, plus a long hold-off on request.
  initial begin
    int run_left;
    int hold_left;
    int hold_seen;
    bit stalling;
    run_left = 0;
    hold_left = 0;
    hold_seen = 0;
    stalling = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 99) < stall_pct);
          run_left = $urandom_range(1, stall_len_max);
        end
        run_left--;
        res_if.ready <= !stalling;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (pending_spheres.size() == 0) begin
        $error("unexpected result transfer: no sphere pending");
        mismatches++;
      end else begin
        want = pending_spheres.pop_front();
        check_field("min_x", want.min_x, got.min_x);
        check_field("min_y", want.min_y, got.min_y);
        check_field("min_z", want.min_z, got.min_z);
        check_field("max_x", want.max_x, got.max_x);
        check_field("max_y", want.max_y, got.max_y);
        check_field("max_z", want.max_z, got.max_z);
        check_field("center_x", want.center_x, got.center_x);
        check_field("center_y", want.center_y, got.center_y);
        check_field("center_z", want.center_z, got.center_z);
        check_field("diagonal", want.diagonal, got.diagonal);
        spheres_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d spheres pending.",
               cycle_count, pending_spheres.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    vtx_if.valid <= 1'b0;
    vtx_if.data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 1, 0, 1);
    test_single_vertex();
    set_idling(3, 4, 30, 5);
    test_extreme_box();
    test_center_rounding();
    test_reseed();
    wait_for_spheres();

    set_idling(0, 1, 0, 1);
    test_random_meshes(400, 40, 1'b0);
    set_idling(12, 6, 0, 1);
    test_random_meshes(400, 40, 1'b0);
    set_idling(0, 1, 60, 16);
    test_random_meshes(400, 40, 1'b0);
    test_backpressure();
    set_idling(6, 8, 35, 10);
    test_random_meshes(400, 40, 1'b1);
    set_idling(2, 10, 20, 6);
    test_random_meshes(300, 64, 1'b0);

    wait_for_spheres();
    repeat (60) @(posedge clk);

    $display("Sent %0d vertices in %0d meshes; checked %0d bounding spheres, %0d mismatches.",
             vertices_sent, meshes_sent, spheres_checked, mismatches);
    if (mismatches == 0 && pending_spheres.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mbs_pkg.sv
rtl/mbs_vtx_if.sv
rtl/mbs_res_if.sv
rtl/mbs_sqrt.sv
rtl/mesh_bounding_sphere.sv
tb/mesh_bounding_sphere_tb.sv
